FILE: hdl/fcsg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_pkg: shared definitions for the filled circle span generator
// widths, limits, sequencer states and the square root request/response types
// ----------------------------------------------------------------------------
package fcsg_pkg;

	localparam int COORD_W    = 12;   // input coordinate field width
	localparam int SPAN_W     = 13;   // output coordinate width
	localparam int RAD_W      = 5;    // radius field width
	localparam int MAX_RADIUS = 31;   // radius saturation limit
	localparam int COORD_BITS = 12;   // significant bits of a center field

	localparam int DY_W   = RAD_W + 1;        // signed row offset
	localparam int SQR_W  = 2 * RAD_W;        // radius squared
	localparam int ROOT_W = 2 * RAD_W + 1;    // working width of the root unit

	localparam logic [RAD_W-1:0] MAX_RAD_C = RAD_W'(MAX_RADIUS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ROW,
		ST_WAIT
	} fcsg_state_t;

	typedef struct packed {
		logic             start;
		logic [SQR_W-1:0] operand;
	} sq_req_t;

	typedef struct packed {
		logic             done;
		logic [RAD_W-1:0] root;
	} sq_rsp_t;

	// take the low COORD_BITS bits as two's complement, widen to the span width
	function automatic logic signed [SPAN_W-1:0] coord_ext(input logic [COORD_W-1:0] f);
		logic [SPAN_W-1:0] r;
		for (int i = 0; i < SPAN_W; i++) begin
			if (i < COORD_BITS && i < COORD_W)
				r[i] = f[i];
			else if (COORD_BITS > COORD_W)
				r[i] = 1'b0;
			else
				r[i] = f[COORD_BITS-1];
		end
		return signed'(r);
	endfunction

endpackage

FILE: hdl/fcsg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg channel interfaces
// circle request channel and span result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface circle_if;
	logic                              valid;
	logic                              ready;
	logic signed [fcsg_pkg::COORD_W-1:0] center_x;
	logic signed [fcsg_pkg::COORD_W-1:0] center_y;
	logic        [fcsg_pkg::RAD_W-1:0]   radius;

	modport source (output valid, center_x, center_y, radius, input ready);
	modport sink   (input valid, center_x, center_y, radius, output ready);
endinterface

interface span_if;
	logic                               valid;
	logic                               ready;
	logic signed [fcsg_pkg::SPAN_W-1:0] span_row;
	logic signed [fcsg_pkg::SPAN_W-1:0] span_start;
	logic signed [fcsg_pkg::SPAN_W-1:0] span_end;
	logic                               last_span;

	modport source (output valid, span_row, span_start, span_end, last_span, input ready);
	modport sink   (input valid, span_row, span_start, span_end, last_span, output ready);
endinterface

FILE: hdl/fcsg_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcsg_isqrt: iterative integer square root
// floor root of a ten-bit value, one radix-4 digit per cycle, done low in busy cycles
// ----------------------------------------------------------------------------
module fcsg_isqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  fcsg_pkg::sq_req_t req,
	output fcsg_pkg::sq_rsp_t rsp
);
	import fcsg_pkg::*;

	logic              busy_q;
	logic [ROOT_W-1:0] n_q;
	logic [ROOT_W-1:0] root_q;
	logic [ROOT_W-1:0] bit_q;
	logic [ROOT_W:0]   trial;
	logic              take;

	assign trial = {1'b0, root_q} + {1'b0, bit_q};
	assign take  = {1'b0, n_q} >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (req.start) begin
			busy_q <= 1'b1;
		end else if (busy_q && bit_q == ROOT_W'(1)) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q    <= ROOT_W'(req.operand);
			root_q <= '0;
			bit_q  <= ROOT_W'(1) << (ROOT_W - 1);
		end else if (busy_q) begin
			if (take) begin
				n_q    <= n_q - trial[ROOT_W-1:0];
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign rsp.done = !busy_q;
	assign rsp.root = root_q[RAD_W-1:0];

endmodule

FILE: hdl/filled_circle_span_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filled_circle_span_generator: scanline spans of a filled circle
// one circle request in, 2r+1 horizontal span requests out, top row first
// ----------------------------------------------------------------------------
// usage
//   circle channel: center_x, center_y (two's complement) and radius; a
//   request is taken only while the block is idle, radius saturates at the
//   configured maximum
//   span channel: one request per row, from row offset -r to +r, carrying
//   the row, start and end columns; last_span marks the bottom row
// row sequence
//   each row forms r*r - dy*dy, runs it through the shared radix-4 square
//   root unit and then loads the output register; the root of the next row
//   is started only after the previous span has been loaded
// reset
//   arst_n clears the sequencer, the root unit's busy flag and the output valid
// stalls
//   spans sit in an output register; while the receiver holds ready low the
//   next row is computed and waits, and a new circle is taken as soon as the
//   last span is loaded, even if it is still waiting to be picked up
// ----------------------------------------------------------------------------
module filled_circle_span_generator (
	input logic     clk,
	input logic     arst_n,
	circle_if.sink  circle,
	span_if.source  span
);
	import fcsg_pkg::*;

	fcsg_state_t state_q, state_d;

	// held circle
	logic signed [SPAN_W-1:0] cx_q;
	logic signed [SPAN_W-1:0] cy_q;
	logic [RAD_W-1:0]         r_q;
	logic [SQR_W-1:0]         rr_q;
	logic signed [DY_W-1:0]   dy_q;

	// output register
	logic                     out_valid_q;
	logic signed [SPAN_W-1:0] row_q;
	logic signed [SPAN_W-1:0] start_q;
	logic signed [SPAN_W-1:0] end_q;
	logic                     last_q;

	logic             accept;
	logic [RAD_W-1:0] r_sat;
	logic [RAD_W-1:0] mag;
	logic [SQR_W-1:0] mag_sq;
	logic             slot_free;
	logic             load;
	logic             at_last;
	logic signed [SPAN_W-1:0] half;

	sq_req_t sq_req;
	sq_rsp_t sq_rsp;

	fcsg_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (sq_req),
		.rsp    (sq_rsp)
	);

	assign accept = circle.valid && circle.ready;
	assign r_sat  = (circle.radius > MAX_RAD_C) ? MAX_RAD_C : circle.radius;

	// |dy| and its square for the remainder under the root
	assign mag    = dy_q[DY_W-1] ? RAD_W'(-dy_q) : dy_q[RAD_W-1:0];
	assign mag_sq = SQR_W'({{RAD_W{1'b0}}, mag} * {{RAD_W{1'b0}}, mag});

	assign slot_free = !out_valid_q || span.ready;
	assign at_last   = (dy_q == signed'({1'b0, r_q}));
	assign half      = signed'(SPAN_W'(sq_rsp.root));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept)
					state_d = ST_ROW;
			end
			ST_ROW: begin
				state_d = ST_WAIT;
			end
			ST_WAIT: begin
				if (sq_rsp.done && slot_free)
					state_d = at_last ? ST_IDLE : ST_ROW;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		circle.ready   = 1'b0;
		sq_req.start   = 1'b0;
		sq_req.operand = rr_q - mag_sq;
		load           = 1'b0;
		case (state_q)
			ST_IDLE: circle.ready = 1'b1;
			ST_ROW:  sq_req.start = 1'b1;
			ST_WAIT: load = sq_rsp.done && slot_free;
			default: circle.ready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load)
				out_valid_q <= 1'b1;
			else if (span.ready)
				out_valid_q <= 1'b0;
		end
	end

	// circle capture and row walk
	always_ff @(posedge clk) begin
		if (accept) begin
			cx_q <= coord_ext(circle.center_x);
			cy_q <= coord_ext(circle.center_y);
			r_q  <= r_sat;
			rr_q <= SQR_W'({{RAD_W{1'b0}}, r_sat} * {{RAD_W{1'b0}}, r_sat});
			dy_q <= -signed'({1'b0, r_sat});
		end else if (load) begin
			dy_q <= dy_q + DY_W'(1);
		end
	end

	// span payload
	always_ff @(posedge clk) begin
		if (load) begin
			row_q   <= cy_q + SPAN_W'(dy_q);
			start_q <= cx_q - half;
			end_q   <= cx_q + half;
			last_q  <= at_last;
		end
	end

	assign span.valid      = out_valid_q;
	assign span.span_row   = row_q;
	assign span.span_start = start_q;
	assign span.span_end   = end_q;
	assign span.last_span  = last_q;

	// checks
	a_root_busy: assert property (@(posedge clk) disable iff (!arst_n)
		sq_req.start |=> !sq_rsp.done)
		else $error("root unit reports done right after a start");

	a_more_rows: assert property (@(posedge clk) disable iff (!arst_n)
		(span.valid && !span.last_span) |-> (state_q != ST_IDLE))
		else $error("sequencer idle while rows of a circle remain");

	a_accept_row: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ROW && dy_q == -signed'({1'b0, r_q})))
		else $error("circle taken without starting at the top row");

endmodule
